[src/hostname_label_validator_defines.svh]
// Assertion macros shared by the host name validator RTL.
// Needs clk_i and rst_ni in the scope where the macros are used.
`ifndef HOSTNAME_LABEL_VALIDATOR_DEFINES_SVH
`define HOSTNAME_LABEL_VALIDATOR_DEFINES_SVH

// Check a property on every rising edge outside reset.
`define HLV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check a property on every rising edge, reset included.
`define HLV_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

[src/hlv_pkg.sv]
// Package for the host name validator: widths, codes, payload and item types.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package hlv_pkg;

  localparam int CHAR_W      = 8;
  localparam int REASON_W    = 4;
  localparam int LABEL_CNT_W = 7;
  localparam int NAME_CNT_W  = 9;
  localparam int MAX_LABEL_W = 6;
  localparam int MAX_NAME_W  = 8;
  localparam int CFG_DATA_W  = 8;
  localparam int CFG_IDX_W   = 1;

  localparam int HLV_FIFO_DEPTH = 2;

  localparam logic [LABEL_CNT_W-1:0] LABEL_SAT = 7'd127;
  localparam logic [NAME_CNT_W-1:0]  NAME_SAT  = 9'd511;

  localparam logic [MAX_LABEL_W-1:0] MAX_LABEL_RST = 6'd63;
  localparam logic [MAX_NAME_W-1:0]  MAX_NAME_RST  = 8'd253;

  localparam logic [CHAR_W-1:0] DOT_CODE    = 8'h2E;
  localparam logic [CHAR_W-1:0] HYPHEN_CODE = 8'h2D;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LABEL = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_NAME  = 1'd1;

  typedef enum logic [REASON_W-1:0] {
    RSN_OK          = 4'd0,
    RSN_EMPTY       = 4'd1,
    RSN_DOTS        = 4'd2,
    RSN_LONG        = 4'd3,
    RSN_NUMERIC     = 4'd4,
    RSN_EMPTY_LABEL = 4'd5,
    RSN_LONG_LABEL  = 4'd6,
    RSN_HYPHEN      = 4'd7,
    RSN_BAD_CHAR    = 4'd8
  } reason_e;

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              last_char;
    logic              no_char;
  } hlv_in_t;

  typedef struct packed {
    logic                host_valid;
    logic [REASON_W-1:0] reject_reason;
  } hlv_out_t;

  // Classified item handed from the front to the back
  typedef struct packed {
    logic has_byte;
    logic last;
    logic is_dot;
    logic is_hyphen;
    logic letter_or_hyphen;
    logic is_bad;
  } hlv_item_t;

  typedef struct packed {
    logic [MAX_LABEL_W-1:0] max_label_length;
    logic [MAX_NAME_W-1:0]  max_name_length;
  } hlv_cfg_t;

endpackage

`default_nettype wire

[src/hlv_front.sv]
// Front end: takes input transfers and classifies each byte.
// Depends on hlv_pkg; feeds hlv_fifo.
`timescale 1ns / 1ps
`default_nettype none

module hlv_front (
  input  wire logic              in_valid_i,
  input  wire hlv_pkg::hlv_in_t  in_data_i,
  output logic                   in_stall_o,
  input  wire logic              fifo_full_i,
  output logic                   push_o,
  output hlv_pkg::hlv_item_t     item_o
);
  import hlv_pkg::*;

  logic [CHAR_W-1:0] c;
  logic is_letter;
  logic is_digit;

  assign c         = in_data_i.char_code;
  assign is_letter = (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  assign is_digit  = (c >= 8'h30 && c <= 8'h39);

  always_comb begin
    item_o.has_byte         = !in_data_i.no_char;
    item_o.last             = in_data_i.last_char;
    item_o.is_dot           = (c == DOT_CODE);
    item_o.is_hyphen        = (c == HYPHEN_CODE);
    item_o.letter_or_hyphen = is_letter || (c == HYPHEN_CODE);
    item_o.is_bad           = !(is_letter || is_digit || (c == HYPHEN_CODE));
  end

  assign in_stall_o = fifo_full_i;
  assign push_o     = in_valid_i && !fifo_full_i;

endmodule

`default_nettype wire

[src/hlv_fifo.sv]
// Short queue of classified items between front and back.
// Depends on hlv_pkg and the assertion macros header.
`timescale 1ns / 1ps
`default_nettype none
`include "hostname_label_validator_defines.svh"

module hlv_fifo #(
  parameter int Depth = hlv_pkg::HLV_FIFO_DEPTH
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  input  wire hlv_pkg::hlv_item_t  data_i,
  input  wire logic                pop_i,
  output hlv_pkg::hlv_item_t       data_o,
  output logic                     full_o,
  output logic                     empty_o
);
  import hlv_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  hlv_item_t       mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o  = (count_q == FullCnt);
  assign empty_o = (count_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  `HLV_ASSERT(a_no_push_full, full_o |-> !push_i, "push into full queue")
  `HLV_ASSERT(a_no_pop_empty, empty_o |-> !pop_i, "pop from empty queue")
  `HLV_ASSERT(a_count_range, count_q <= FullCnt, "queue count beyond depth")

endmodule

`default_nettype wire

[src/hlv_back.sv]
// Back end: per-name counters and flags, verdict logic and output register.
// Depends on hlv_pkg and the assertion macros header; fed by hlv_fifo.
`timescale 1ns / 1ps
`default_nettype none
`include "hostname_label_validator_defines.svh"

module hlv_back (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire hlv_pkg::hlv_cfg_t   cfg_i,
  input  wire hlv_pkg::hlv_item_t  item_i,
  input  wire logic                empty_i,
  output logic                     pop_o,
  output logic                     out_valid_o,
  output hlv_pkg::hlv_out_t        out_data_o,
  input  wire logic                out_stall_i
);
  import hlv_pkg::*;

  logic [LABEL_CNT_W-1:0] lc_q, lc_d;
  logic [NAME_CNT_W-1:0]  nc_q, nc_d;
  logic                   seen_q, seen_d;
  logic                   pdot_q, pdot_d;
  logic                   phy_q, phy_d;
  logic                   lead_q, lead_d;
  logic                   dpair_q, dpair_d;
  reason_e                fault_q, fault_d;

  logic                   out_valid_q;
  hlv_out_t               out_q;

  reason_e                dot_code;
  reason_e                end_code;
  reason_e                verdict;
  logic [NAME_CNT_W-1:0]  stripped;

  // Check the label that just ended: empty, too long, hyphen at an edge
  function automatic reason_e label_check(input logic [LABEL_CNT_W-1:0] lc,
                                          input logic [MAX_LABEL_W-1:0] max_len,
                                          input logic lead, input logic trail);
    reason_e r;
    if (lc == '0) begin
      r = RSN_EMPTY_LABEL;
    end else if (lc > {1'b0, max_len}) begin
      r = RSN_LONG_LABEL;
    end else if (lead || trail) begin
      r = RSN_HYPHEN;
    end else begin
      r = RSN_OK;
    end
    return r;
  endfunction

  // A final byte needs the output register free or draining
  assign pop_o = !empty_i && (!item_i.last || !out_valid_q || !out_stall_i);

  always_comb begin
    lc_d     = lc_q;
    nc_d     = nc_q;
    seen_d   = seen_q;
    pdot_d   = pdot_q;
    phy_d    = phy_q;
    lead_d   = lead_q;
    dpair_d  = dpair_q;
    fault_d  = fault_q;
    dot_code = label_check(lc_q, cfg_i.max_label_length, lead_q, phy_q);
    if (item_i.has_byte) begin
      if (nc_q != NAME_SAT) begin
        nc_d = nc_q + NAME_CNT_W'(1);
      end
      if (item_i.is_dot) begin
        if (fault_q == RSN_OK) begin
          fault_d = dot_code;
        end
        lc_d    = '0;
        lead_d  = 1'b0;
        dpair_d = pdot_q;
        pdot_d  = 1'b1;
        phy_d   = 1'b0;
      end else begin
        if (item_i.letter_or_hyphen) begin
          seen_d = 1'b1;
        end
        if (item_i.is_bad && fault_q == RSN_OK) begin
          fault_d = RSN_BAD_CHAR;
        end
        if (lc_q == '0) begin
          lead_d = item_i.is_hyphen;
        end
        if (lc_q != LABEL_SAT) begin
          lc_d = lc_q + LABEL_CNT_W'(1);
        end
        dpair_d = 1'b0;
        pdot_d  = 1'b0;
        phy_d   = item_i.is_hyphen;
      end
    end
  end

  // Verdict on the state as it stands after this byte
  always_comb begin
    stripped = nc_d - {{(NAME_CNT_W-1){1'b0}}, pdot_d};
    end_code = label_check(lc_d, cfg_i.max_label_length, lead_d, phy_d);
    if (stripped == '0) begin
      verdict = RSN_EMPTY;
    end else if (dpair_d) begin
      verdict = RSN_DOTS;
    end else if (stripped > {1'b0, cfg_i.max_name_length}) begin
      verdict = RSN_LONG;
    end else if (!seen_d) begin
      verdict = RSN_NUMERIC;
    end else if (!pdot_d && fault_d == RSN_OK) begin
      verdict = end_code;
    end else begin
      verdict = fault_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lc_q    <= '0;
      nc_q    <= '0;
      seen_q  <= 1'b0;
      pdot_q  <= 1'b0;
      phy_q   <= 1'b0;
      lead_q  <= 1'b0;
      dpair_q <= 1'b0;
      fault_q <= RSN_OK;
    end else if (pop_o) begin
      if (item_i.last) begin
        // clear for the next name
        lc_q    <= '0;
        nc_q    <= '0;
        seen_q  <= 1'b0;
        pdot_q  <= 1'b0;
        phy_q   <= 1'b0;
        lead_q  <= 1'b0;
        dpair_q <= 1'b0;
        fault_q <= RSN_OK;
      end else begin
        lc_q    <= lc_d;
        nc_q    <= nc_d;
        seen_q  <= seen_d;
        pdot_q  <= pdot_d;
        phy_q   <= phy_d;
        lead_q  <= lead_d;
        dpair_q <= dpair_d;
        fault_q <= fault_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o && item_i.last) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && item_i.last) begin
      out_q.host_valid    <= (verdict == RSN_OK);
      out_q.reject_reason <= verdict;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `HLV_ASSERT(a_last_gives_result, pop_o && item_i.last |=> out_valid_q,
              "final byte did not load a verdict")
  `HLV_ASSERT(a_clear_after_name, pop_o && item_i.last |=> nc_q == '0 && fault_q == RSN_OK,
              "name state not cleared after verdict")
  `HLV_ASSERT(a_valid_matches_reason,
              out_valid_q |-> out_q.host_valid == (out_q.reject_reason == RSN_OK),
              "host_valid disagrees with reject_reason")

endmodule

`default_nettype wire

[src/hostname_label_validator.sv]
// Channel   Direction  Payload         Handshake
// in        input      hlv_in_t        in_valid_i / in_stall_o
// out       output     hlv_out_t       out_valid_o / out_stall_i
// cfg       input      8-bit write     cfg_we_i, cfg_idx_i, cfg_data_i
//
// One byte per cycle sustained unless a stalled output holds a final byte at the
// queue head; with an empty queue the final byte is written into the queue and
// then its verdict into the output register; the back end's update sets the rate.
// Reset is asynchronous, clears counters and queue and sets limits to 63 and 253.
// A stalled output only blocks the queue when a final byte reaches its head;
// the queue absorbs up to FifoDepth - 1 further bytes before in_stall_o rises.
// Top level of the host name validator: limit registers and the three parts.
// Depends on hlv_pkg, hlv_front, hlv_fifo and hlv_back.
`timescale 1ns / 1ps
`default_nettype none

module hostname_label_validator #(
  parameter int FifoDepth = hlv_pkg::HLV_FIFO_DEPTH
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 in_valid_i,
  input  wire hlv_pkg::hlv_in_t                     in_data_i,
  output logic                                      in_stall_o,
  output logic                                      out_valid_o,
  output hlv_pkg::hlv_out_t                         out_data_o,
  input  wire logic                                 out_stall_i,
  input  wire logic                                 cfg_we_i,
  input  wire logic [hlv_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  wire logic [hlv_pkg::CFG_DATA_W-1:0]       cfg_data_i
);
  import hlv_pkg::*;

  hlv_cfg_t  cfg_q;
  hlv_item_t front_item;
  hlv_item_t head_item;
  logic      push;
  logic      pop;
  logic      fifo_full;
  logic      fifo_empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_label_length <= MAX_LABEL_RST;
      cfg_q.max_name_length  <= MAX_NAME_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MAX_LABEL: cfg_q.max_label_length <= cfg_data_i[MAX_LABEL_W-1:0];
        CFG_MAX_NAME:  cfg_q.max_name_length  <= cfg_data_i[MAX_NAME_W-1:0];
        default: begin
        end
      endcase
    end
  end

  hlv_front u_front (
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .in_stall_o  (in_stall_o),
    .fifo_full_i (fifo_full),
    .push_o      (push),
    .item_o      (front_item)
  );

  hlv_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_item),
    .pop_i   (pop),
    .data_o  (head_item),
    .full_o  (fifo_full),
    .empty_o (fifo_empty)
  );

  hlv_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .item_i      (head_item),
    .empty_i     (fifo_empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .out_stall_i (out_stall_i)
  );

endmodule

`default_nettype wire
